// File: sv/fjot_pkg.sv
// ---------------------------------------------------------------------------
// fjot_pkg
// shared types, codes and character tables for the flat json object tokenizer
// ---------------------------------------------------------------------------
`default_nettype none

package fjot_pkg;

    localparam int unsigned MAX_PAIRS = 128;
    localparam int unsigned PAIR_W    = 8;
    localparam int unsigned NUM_W     = 31;

    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

    // event codes
    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_OPEN      = 4'd1;
    localparam logic [3:0] EV_KEY_BYTE  = 4'd2;
    localparam logic [3:0] EV_KEY_END   = 4'd3;
    localparam logic [3:0] EV_STR_BYTE  = 4'd4;
    localparam logic [3:0] EV_STR_END   = 4'd5;
    localparam logic [3:0] EV_BOOL      = 4'd6;
    localparam logic [3:0] EV_NULL      = 4'd7;
    localparam logic [3:0] EV_RESERVED  = 4'd8;
    localparam logic [3:0] EV_DOC_OK    = 4'd9;
    localparam logic [3:0] EV_ERROR     = 4'd10;

    // error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_START  = 3'd1;
    localparam logic [2:0] ERR_BAD_KEY    = 3'd2;
    localparam logic [2:0] ERR_NO_COLON   = 3'd3;
    localparam logic [2:0] ERR_BAD_VALUE  = 3'd4;
    localparam logic [2:0] ERR_NO_COMMA   = 3'd5;
    localparam logic [2:0] ERR_TOO_MANY   = 3'd6;
    localparam logic [2:0] ERR_OPEN_STR   = 3'd7;

    // literal kinds
    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef enum logic [3:0] {
        PH_WAIT   = 4'd0,
        PH_FIRST  = 4'd1,
        PH_KEY    = 4'd2,
        PH_COLON  = 4'd3,
        PH_VALUE  = 4'd4,
        PH_STRING = 4'd5,
        PH_LIT    = 4'd6,
        PH_NUMBER = 4'd7,
        PH_AFTER  = 4'd8,
        PH_NEXT   = 4'd9,
        PH_SINK   = 4'd10
    } phase_t;

    typedef struct packed {
        phase_t            phase;
        logic [1:0]        lit_kind;
        logic [2:0]        lit_pos;
        logic [NUM_W-1:0]  acc;
        logic [PAIR_W-1:0] pair_count;
    } state_t;

    typedef struct packed {
        logic [3:0]       event_res;
        logic [7:0]       data_byte;
        logic             bool_flag;
        logic             number_done;
        logic [NUM_W-1:0] number_value;
        logic [6:0]       pair_index;
        logic [2:0]       error_kind;
    } result_t;

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        case (kind)
            LIT_TRUE:  lit_len = 3'd4;
            LIT_FALSE: lit_len = 3'd5;
            LIT_NULL:  lit_len = 3'd4;
            default:   lit_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] ch;
        ch = CH_NUL;
        case (kind)
            LIT_TRUE:
            begin
                case (pos)
                    3'd0:    ch = CH_T;
                    3'd1:    ch = CH_R;
                    3'd2:    ch = CH_U;
                    3'd3:    ch = CH_E;
                    default: ch = CH_NUL;
                endcase
            end
            LIT_FALSE:
            begin
                case (pos)
                    3'd0:    ch = CH_F;
                    3'd1:    ch = CH_A;
                    3'd2:    ch = CH_L;
                    3'd3:    ch = CH_S;
                    3'd4:    ch = CH_E;
                    default: ch = CH_NUL;
                endcase
            end
            LIT_NULL:
            begin
                case (pos)
                    3'd0:    ch = CH_N;
                    3'd1:    ch = CH_U;
                    3'd2:    ch = CH_L;
                    3'd3:    ch = CH_L;
                    default: ch = CH_NUL;
                endcase
            end
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

// File: sv/flat_json_object_tokenizer_core.sv
// ---------------------------------------------------------------------------
// flat_json_object_tokenizer_core
// streaming tokenizer for a flat json object, one text byte per request
// ---------------------------------------------------------------------------
// Each accepted text byte produces exactly one result request, in the
// cycle after it is taken. The parser state and the result register are
// updated in the same cycle, so a new byte is taken every clock as long as
// the result register is empty or being read in that cycle; text_stall
// rises only while a result waits under res_stall. The output is registered
// in the single result register after the per-byte decode logic.
`default_nettype none

module flat_json_object_tokenizer_core (
    input  wire  logic        clk,
    input  wire  logic        rst_n,
    input  wire  logic        text_valid,
    output logic              text_stall,
    input  wire  logic [7:0]  text_byte,
    output logic              res_valid,
    input  wire  logic        res_stall,
    output logic [3:0]        event_res,
    output logic [7:0]        data_byte,
    output logic              bool_flag,
    output logic              number_done,
    output logic [30:0]       number_value,
    output logic [6:0]        pair_index,
    output logic [2:0]        error_kind
);
    import fjot_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    result_t res_reg;
    result_t res_next;
    logic    res_valid_reg;
    logic    take;

    assign text_stall = res_valid_reg & res_stall;
    assign take       = text_valid & ~text_stall;

    fjot_step u_step (
        .cur_state  (state_reg),
        .text_byte  (text_byte),
        .next_state (state_next),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= PH_WAIT;
            state_reg.lit_kind   <= '0;
            state_reg.lit_pos    <= '0;
            state_reg.acc        <= '0;
            state_reg.pair_count <= '0;
            res_valid_reg        <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg     <= state_next;
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid    = res_valid_reg;
    assign event_res    = res_reg.event_res;
    assign data_byte    = res_reg.data_byte;
    assign bool_flag    = res_reg.bool_flag;
    assign number_done  = res_reg.number_done;
    assign number_value = res_reg.number_value;
    assign pair_index   = res_reg.pair_index;
    assign error_kind   = res_reg.error_kind;

endmodule

`default_nettype wire

// File: sv/fjot_step.sv
// ---------------------------------------------------------------------------
// fjot_step
// per-byte next state and result logic of the tokenizer
// ---------------------------------------------------------------------------
`default_nettype none

module fjot_step (
    input  wire fjot_pkg::state_t  cur_state,
    input  wire logic [7:0]        text_byte,
    output fjot_pkg::state_t       next_state,
    output fjot_pkg::result_t      result
);
    import fjot_pkg::*;

    logic [6:0]       cur_pair;
    logic [NUM_W+3:0] acc_wide;
    logic [NUM_W-1:0] acc_sat;
    logic [3:0]       digit;
    logic [2:0]       lit_pos_inc;

    assign digit       = text_byte[3:0];
    assign lit_pos_inc = cur_state.lit_pos + 3'd1;
    assign cur_pair    = (cur_state.pair_count == '0) ? 7'd0
                         : 7'(cur_state.pair_count - PAIR_W'(1));

    // acc * 10 + digit, saturating
    assign acc_wide = ({4'b0, cur_state.acc} << 3) + ({4'b0, cur_state.acc} << 1)
                      + {{NUM_W{1'b0}}, digit};
    assign acc_sat  = (acc_wide > {4'b0, NUM_MAX}) ? NUM_MAX : acc_wide[NUM_W-1:0];

    always_comb
    begin
        phase_t ph;
        logic   done;
        logic   do_fail;
        logic   fail_in_pair;
        logic   do_start_key;
        logic [2:0] fail_kind;

        next_state   = cur_state;
        result       = '0;
        ph           = cur_state.phase;
        done         = 1'b0;
        do_fail      = 1'b0;
        fail_in_pair = 1'b0;
        do_start_key = 1'b0;
        fail_kind    = ERR_NONE;

        // number in progress: a digit extends it, anything else ends it
        if (ph == PH_NUMBER)
        begin
            if (is_digit(text_byte))
            begin
                next_state.acc = acc_sat;
                done           = 1'b1;
            end
            else
            begin
                result.number_done  = 1'b1;
                result.number_value = cur_state.acc;
                result.pair_index   = cur_pair;
                ph                  = PH_AFTER;
                next_state.phase    = PH_AFTER;
            end
        end

        if (!done)
        begin
            case (ph)
                PH_WAIT:
                begin
                    if (text_byte == CH_LBRACE)
                    begin
                        result.event_res      = EV_OPEN;
                        next_state.pair_count = '0;
                        next_state.lit_kind   = '0;
                        next_state.lit_pos    = '0;
                        next_state.acc        = '0;
                        next_state.phase      = PH_FIRST;
                    end
                    else if (!is_space(text_byte))
                    begin
                        do_fail   = 1'b1;
                        fail_kind = ERR_BAD_START;
                    end
                end
                PH_FIRST, PH_AFTER:
                begin
                    if (!is_space(text_byte))
                    begin
                        if (text_byte == CH_RBRACE || text_byte == CH_NUL)
                        begin
                            result.event_res = EV_DOC_OK;
                            next_state.phase = (text_byte == CH_NUL) ? PH_WAIT : PH_SINK;
                        end
                        else if (ph == PH_FIRST)
                        begin
                            if (text_byte == CH_QUOTE)
                            begin
                                do_start_key = 1'b1;
                            end
                            else
                            begin
                                do_fail   = 1'b1;
                                fail_kind = ERR_BAD_KEY;
                            end
                        end
                        else if (text_byte == CH_COMMA)
                        begin
                            next_state.phase = PH_NEXT;
                        end
                        else
                        begin
                            do_fail      = 1'b1;
                            fail_kind    = ERR_NO_COMMA;
                            fail_in_pair = 1'b1;
                        end
                    end
                end
                PH_NEXT:
                begin
                    if (!is_space(text_byte))
                    begin
                        if (text_byte == CH_QUOTE)
                        begin
                            do_start_key = 1'b1;
                        end
                        else
                        begin
                            do_fail   = 1'b1;
                            fail_kind = ERR_BAD_KEY;
                        end
                    end
                end
                PH_KEY, PH_STRING:
                begin
                    if (text_byte == CH_NUL)
                    begin
                        do_fail      = 1'b1;
                        fail_kind    = ERR_OPEN_STR;
                        fail_in_pair = 1'b1;
                    end
                    else if (text_byte == CH_QUOTE)
                    begin
                        result.event_res  = (ph == PH_KEY) ? EV_KEY_END : EV_STR_END;
                        result.pair_index = cur_pair;
                        next_state.phase  = (ph == PH_KEY) ? PH_COLON : PH_AFTER;
                    end
                    else
                    begin
                        result.event_res  = (ph == PH_KEY) ? EV_KEY_BYTE : EV_STR_BYTE;
                        result.data_byte  = text_byte;
                        result.pair_index = cur_pair;
                    end
                end
                PH_COLON:
                begin
                    if (!is_space(text_byte))
                    begin
                        if (text_byte == CH_COLON)
                        begin
                            next_state.phase = PH_VALUE;
                        end
                        else
                        begin
                            do_fail      = 1'b1;
                            fail_kind    = ERR_NO_COLON;
                            fail_in_pair = 1'b1;
                        end
                    end
                end
                PH_VALUE:
                begin
                    if (!is_space(text_byte))
                    begin
                        if (text_byte == CH_QUOTE)
                        begin
                            next_state.phase = PH_STRING;
                        end
                        else if (text_byte == CH_T || text_byte == CH_F || text_byte == CH_N)
                        begin
                            next_state.lit_kind = (text_byte == CH_T) ? LIT_TRUE
                                                : (text_byte == CH_F) ? LIT_FALSE : LIT_NULL;
                            next_state.lit_pos  = 3'd1;
                            next_state.phase    = PH_LIT;
                        end
                        else if (is_digit(text_byte))
                        begin
                            next_state.acc   = {{(NUM_W-4){1'b0}}, digit};
                            next_state.phase = PH_NUMBER;
                        end
                        else
                        begin
                            do_fail      = 1'b1;
                            fail_kind    = ERR_BAD_VALUE;
                            fail_in_pair = 1'b1;
                        end
                    end
                end
                PH_LIT:
                begin
                    if (cur_state.lit_kind > LIT_NULL
                        || cur_state.lit_pos >= lit_len(cur_state.lit_kind)
                        || text_byte != lit_char(cur_state.lit_kind, cur_state.lit_pos))
                    begin
                        do_fail      = 1'b1;
                        fail_kind    = ERR_BAD_VALUE;
                        fail_in_pair = 1'b1;
                    end
                    else
                    begin
                        next_state.lit_pos = lit_pos_inc;
                        if (lit_pos_inc == lit_len(cur_state.lit_kind))
                        begin
                            result.event_res  = (cur_state.lit_kind == LIT_NULL) ? EV_NULL
                                                                                 : EV_BOOL;
                            result.bool_flag  = (cur_state.lit_kind == LIT_TRUE);
                            result.pair_index = cur_pair;
                            next_state.phase  = PH_AFTER;
                        end
                    end
                end
                default:
                begin
                    if (text_byte == CH_NUL)
                    begin
                        next_state.phase = PH_WAIT;
                    end
                end
            endcase

            // opening quote of a key
            if (do_start_key)
            begin
                if (cur_state.pair_count >= PAIR_W'(MAX_PAIRS))
                begin
                    do_fail   = 1'b1;
                    fail_kind = ERR_TOO_MANY;
                end
                else
                begin
                    next_state.pair_count = cur_state.pair_count + PAIR_W'(1);
                    next_state.phase      = PH_KEY;
                end
            end

            if (do_fail)
            begin
                result.event_res  = EV_ERROR;
                result.error_kind = fail_kind;
                if (fail_in_pair)
                begin
                    result.pair_index = cur_pair;
                end
                next_state.phase = (text_byte == CH_NUL) ? PH_WAIT : PH_SINK;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/fjot_checker.sv
// ---------------------------------------------------------------------------
// fjot_checker
// port level checks for the tokenizer, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

module fjot_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        text_valid,
    input wire logic        text_stall,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic [3:0]  event_res,
    input wire logic [7:0]  data_byte,
    input wire logic        number_done,
    input wire logic [30:0] number_value,
    input wire logic [2:0]  error_kind
);
    import fjot_pkg::*;

    // every request taken shows up as a result the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_stall |=> res_valid)
        else $error("accepted byte produced no result");

    // a stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(event_res) && $stable(data_byte))
        else $error("stalled result changed");

    // error code present exactly on error events
    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((event_res == EV_ERROR) == (error_kind != ERR_NONE)))
        else $error("error code does not match event");

    // data byte only on key and string bytes
    a_data_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_res != EV_KEY_BYTE && event_res != EV_STR_BYTE
        |-> data_byte == 8'd0)
        else $error("data byte set on wrong event");

    // number value only with number done
    a_number_value: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !number_done |-> number_value == '0)
        else $error("number value without number done");

endmodule

bind flat_json_object_tokenizer_core fjot_checker u_fjot_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .event_res    (event_res),
    .data_byte    (data_byte),
    .number_done  (number_done),
    .number_value (number_value),
    .error_kind   (error_kind)
);

`default_nettype wire
